// ----- hw/rtl/dense_to_sparse_coo_rows_top_defines.svh -----
// ----------------------------------------------------------------------------
// Dense to sparse COO rows: assertion macros
// Shared property forms for the checker. Each macro samples on clk and is
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DENSE_TO_SPARSE_COO_ROWS_TOP_DEFINES_SVH
`define DENSE_TO_SPARSE_COO_ROWS_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTSC_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTSC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/dtsc_pkg.sv -----
// ----------------------------------------------------------------------------
// dtsc_pkg
// Constants, register codes and shared types of the dense to sparse COO block.
// ----------------------------------------------------------------------------
`default_nettype none

package dtsc_pkg;

	localparam int MAX_ROW_LEN     = 64;
	localparam int MAX_SPARSE_DIMS = 4;

	localparam int POS_W      = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
	localparam int LEN_W      = $clog2(MAX_ROW_LEN + 1);
	localparam int DIMS_W     = $clog2(MAX_SPARSE_DIMS + 1);
	localparam int ELEM_W     = 64;
	localparam int COORD_W    = 20;
	localparam int DIM_W      = 21;
	localparam int IDX_W      = 32;
	localparam int ELEM_POS_W = 6;
	localparam int ROWLEN_W   = 7;
	localparam int SDIMS_W    = 3;
	localparam int NUM_REGS   = 7;
	localparam int ADDR_W     = $clog2(NUM_REGS * 4);
	localparam int REG_IDX_W  = ADDR_W - 2;
	localparam int DATA_W     = 32;
	localparam int MEM_AW     = POS_W + 1;

	localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(1048576);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SPARSE_DIMS    = 3'd0,
		REG_DIM_SIZE_0     = 3'd1,
		REG_DIM_SIZE_1     = 3'd2,
		REG_DIM_SIZE_2     = 3'd3,
		REG_DIM_SIZE_3     = 3'd4,
		REG_ROW_LEN        = 3'd5,
		REG_ELEM_IS_DOUBLE = 3'd6
	} reg_idx_t;

	typedef enum logic [0:0] {
		EMIT_IDLE = 1'b0,
		EMIT_RUN  = 1'b1
	} emit_state_t;

	typedef logic [MAX_SPARSE_DIMS-1:0][COORD_W-1:0] coords_t;
	typedef logic [MAX_SPARSE_DIMS-1:0][DIM_W-1:0]   dim_sizes_t;

	// Write port of the row buffer.
	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
		logic [ELEM_W-1:0] data;
	} mem_wr_t;

	// One completed nonzero row handed to the emitter.
	typedef struct packed {
		logic             valid;
		logic             bank;
		logic [LEN_W-1:0] len;
		coords_t          coords;
		logic [IDX_W-1:0] row_idx;
		logic             dbl;
	} emit_job_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dtsc_coord_cnt.sv -----
// ----------------------------------------------------------------------------
// dtsc_coord_cnt
// Mixed-radix row coordinate counter, last used dimension fastest.
// ----------------------------------------------------------------------------
`default_nettype none

module dtsc_coord_cnt (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  clear,
	input  logic                                  advance,
	input  logic [dtsc_pkg::SDIMS_W-1:0]          sparse_dims,
	input  dtsc_pkg::dim_sizes_t                  dim_size,
	output dtsc_pkg::coords_t                     coords
);

	dtsc_pkg::coords_t                  coords_q;
	dtsc_pkg::coords_t                  base;
	dtsc_pkg::coords_t                  nxt;
	dtsc_pkg::dim_sizes_t               size_eff;
	logic [dtsc_pkg::MAX_SPARSE_DIMS-1:0][dtsc_pkg::DIM_W-1:0] plus;
	logic [dtsc_pkg::MAX_SPARSE_DIMS-1:0] wrap;
	logic [dtsc_pkg::DIMS_W-1:0]        dims_eff;

	always_comb begin
		if (sparse_dims == '0) begin
			dims_eff = dtsc_pkg::DIMS_W'(1);
		end else if (dtsc_pkg::DIMS_W'(sparse_dims) > dtsc_pkg::DIMS_W'(dtsc_pkg::MAX_SPARSE_DIMS)) begin
			dims_eff = dtsc_pkg::DIMS_W'(dtsc_pkg::MAX_SPARSE_DIMS);
		end else begin
			dims_eff = dtsc_pkg::DIMS_W'(sparse_dims);
		end
	end

	always_comb begin
		for (int k = 0; k < dtsc_pkg::MAX_SPARSE_DIMS; k++) begin
			if (dim_size[k] == '0) begin
				size_eff[k] = dtsc_pkg::DIM_W'(1);
			end else if (dim_size[k] > dtsc_pkg::DIM_LIMIT) begin
				size_eff[k] = dtsc_pkg::DIM_LIMIT;
			end else begin
				size_eff[k] = dim_size[k];
			end
			base[k] = clear ? '0 : coords_q[k];
			plus[k] = dtsc_pkg::DIM_W'(base[k]) + dtsc_pkg::DIM_W'(1);
			wrap[k] = plus[k] >= size_eff[k];
		end
	end

	// The carry ripples from the fastest used dimension toward dimension 0.
	always_comb begin
		logic carry;
		carry = 1'b1;
		for (int k = dtsc_pkg::MAX_SPARSE_DIMS - 1; k >= 0; k--) begin
			nxt[k] = base[k];
			if (k < int'(dims_eff)) begin
				if (carry) begin
					nxt[k] = wrap[k] ? '0 : plus[k][dtsc_pkg::COORD_W-1:0];
				end
				carry = carry & wrap[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coords_q <= '0;
		end else if (advance) begin
			coords_q <= nxt;
		end else if (clear) begin
			coords_q <= base;
		end
	end

	// Unused dimensions keep their value until a clear, but read as zero.
	always_comb begin
		for (int k = 0; k < dtsc_pkg::MAX_SPARSE_DIMS; k++) begin
			coords[k] = (k < int'(dims_eff)) ? base[k] : '0;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/dtsc_row_emit.sv -----
// ----------------------------------------------------------------------------
// dtsc_row_emit
// Two-bank row buffer and the emitter that streams a kept row out of it.
// ----------------------------------------------------------------------------
`default_nettype none

module dtsc_row_emit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dtsc_pkg::mem_wr_t                  wr,
	input  dtsc_pkg::emit_job_t                job,
	output logic                               busy,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [dtsc_pkg::ELEM_W-1:0]        out_bits,
	output dtsc_pkg::coords_t                  out_coords,
	output logic [dtsc_pkg::ELEM_POS_W-1:0]    elem_pos,
	output logic [dtsc_pkg::IDX_W-1:0]         nz_row_index,
	output logic                               row_last
);

	logic [dtsc_pkg::ELEM_W-1:0] row_mem [2**dtsc_pkg::MEM_AW];

	dtsc_pkg::emit_state_t        state_q;
	dtsc_pkg::emit_state_t        state_nxt;
	dtsc_pkg::emit_job_t          job_q;
	logic [dtsc_pkg::POS_W-1:0]   rd_pos_q;
	logic                         rd_en;
	logic                         last_rd;
	logic                         out_valid_q;

	logic [dtsc_pkg::ELEM_W-1:0]  rd_data_s1;
	logic [dtsc_pkg::POS_W-1:0]   pos_s1;
	logic                         last_s1;
	dtsc_pkg::coords_t            coords_s1;
	logic [dtsc_pkg::IDX_W-1:0]   idx_s1;
	logic                         dbl_s1;

	assign last_rd = (dtsc_pkg::LEN_W'(rd_pos_q) + dtsc_pkg::LEN_W'(1)) == job_q.len;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dtsc_pkg::EMIT_IDLE: begin
				if (job.valid) state_nxt = dtsc_pkg::EMIT_RUN;
			end
			dtsc_pkg::EMIT_RUN: begin
				if (rd_en && last_rd) state_nxt = dtsc_pkg::EMIT_IDLE;
			end
			default: state_nxt = dtsc_pkg::EMIT_IDLE;
		endcase
	end

	always_comb begin
		busy  = (state_q == dtsc_pkg::EMIT_RUN);
		rd_en = (state_q == dtsc_pkg::EMIT_RUN) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dtsc_pkg::EMIT_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (rd_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dtsc_pkg::EMIT_IDLE && job.valid) begin
			job_q    <= job;
			rd_pos_q <= '0;
		end else if (rd_en) begin
			rd_pos_q <= rd_pos_q + dtsc_pkg::POS_W'(1);
		end
		if (rd_en) begin
			pos_s1    <= rd_pos_q;
			last_s1   <= last_rd;
			coords_s1 <= job_q.coords;
			idx_s1    <= job_q.row_idx;
			dbl_s1    <= job_q.dbl;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) row_mem[wr.addr] <= wr.data;
		if (rd_en) rd_data_s1 <= row_mem[{job_q.bank, rd_pos_q}];
	end

	assign out_valid    = out_valid_q;
	assign out_bits     = dbl_s1 ? rd_data_s1 : {32'b0, rd_data_s1[31:0]};
	assign out_coords   = coords_s1;
	assign elem_pos     = dtsc_pkg::ELEM_POS_W'(pos_s1);
	assign nz_row_index = idx_s1;
	assign row_last     = last_s1;

endmodule

`default_nettype wire

// ----- hw/rtl/dense_to_sparse_coo_rows_top.sv -----
// A kept row's job is registered in the emitter when the transaction
// that completes the row is accepted; its first element then passes the
// registered read stage, and the rest follow one per cycle while out_ready is
// high. The element ending a row waits until the emitter has read the last
// entry of the previous kept row. Reset: asynchronous and active low; only
// control registers are reset; the row buffer and datapath registers are not.
// ----------------------------------------------------------------------------
// dense_to_sparse_coo_rows_top
// Converts a row-major dense tensor stream into COO rows over its leading
// sparse dimensions, dropping rows whose elements are all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module dense_to_sparse_coo_rows_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// APB-style configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dtsc_pkg::ADDR_W-1:0]       paddr,
	input  logic [dtsc_pkg::DATA_W-1:0]       pwdata,
	output logic [dtsc_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	// Dense element input
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [dtsc_pkg::ELEM_W-1:0]       elem_bits,
	input  logic                              tensor_start,
	// Sparse result output
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [dtsc_pkg::ELEM_W-1:0]       out_bits,
	output logic [dtsc_pkg::COORD_W-1:0]      coord_0,
	output logic [dtsc_pkg::COORD_W-1:0]      coord_1,
	output logic [dtsc_pkg::COORD_W-1:0]      coord_2,
	output logic [dtsc_pkg::COORD_W-1:0]      coord_3,
	output logic [dtsc_pkg::ELEM_POS_W-1:0]   elem_pos,
	output logic [dtsc_pkg::IDX_W-1:0]        nz_row_index,
	output logic                              row_last
);

	// ------------------------------------------------------------------
	// Configuration registers. The register index is the word address.
	// ------------------------------------------------------------------
	logic [dtsc_pkg::SDIMS_W-1:0]  sparse_dims_q;
	dtsc_pkg::dim_sizes_t          dim_size_q;
	logic [dtsc_pkg::ROWLEN_W-1:0] row_len_q;
	logic                          elem_dbl_q;
	logic [dtsc_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[dtsc_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sparse_dims_q <= dtsc_pkg::SDIMS_W'(1);
			for (int k = 0; k < dtsc_pkg::MAX_SPARSE_DIMS; k++) begin
				dim_size_q[k] <= dtsc_pkg::DIM_W'(1);
			end
			row_len_q  <= dtsc_pkg::ROWLEN_W'(1);
			elem_dbl_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				dtsc_pkg::REG_SPARSE_DIMS:    sparse_dims_q <= pwdata[dtsc_pkg::SDIMS_W-1:0];
				dtsc_pkg::REG_DIM_SIZE_0:     dim_size_q[0] <= pwdata[dtsc_pkg::DIM_W-1:0];
				dtsc_pkg::REG_DIM_SIZE_1:     dim_size_q[1] <= pwdata[dtsc_pkg::DIM_W-1:0];
				dtsc_pkg::REG_DIM_SIZE_2:     dim_size_q[2] <= pwdata[dtsc_pkg::DIM_W-1:0];
				dtsc_pkg::REG_DIM_SIZE_3:     dim_size_q[3] <= pwdata[dtsc_pkg::DIM_W-1:0];
				dtsc_pkg::REG_ROW_LEN:        row_len_q     <= pwdata[dtsc_pkg::ROWLEN_W-1:0];
				dtsc_pkg::REG_ELEM_IS_DOUBLE: elem_dbl_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			dtsc_pkg::REG_SPARSE_DIMS:    prdata = dtsc_pkg::DATA_W'(sparse_dims_q);
			dtsc_pkg::REG_DIM_SIZE_0:     prdata = dtsc_pkg::DATA_W'(dim_size_q[0]);
			dtsc_pkg::REG_DIM_SIZE_1:     prdata = dtsc_pkg::DATA_W'(dim_size_q[1]);
			dtsc_pkg::REG_DIM_SIZE_2:     prdata = dtsc_pkg::DATA_W'(dim_size_q[2]);
			dtsc_pkg::REG_DIM_SIZE_3:     prdata = dtsc_pkg::DATA_W'(dim_size_q[3]);
			dtsc_pkg::REG_ROW_LEN:        prdata = dtsc_pkg::DATA_W'(row_len_q);
			dtsc_pkg::REG_ELEM_IS_DOUBLE: prdata = dtsc_pkg::DATA_W'(elem_dbl_q);
			default:                      prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Row assembly. Each element is written into the current buffer bank at
	// its row position. A row of zero length counts as one element, and a
	// length above the buffer depth is clamped to the depth.
	// ------------------------------------------------------------------
	logic [dtsc_pkg::LEN_W-1:0]  len_eff;
	logic [dtsc_pkg::POS_W-1:0]  pos_q;
	logic [dtsc_pkg::POS_W-1:0]  pos_base;
	logic [dtsc_pkg::LEN_W-1:0]  pos_inc;
	logic                        row_nz_q;
	logic                        row_nz_new;
	logic                        elem_nz;
	logic                        row_end;
	logic                        may_end;
	logic                        wr_bank_q;
	logic [dtsc_pkg::IDX_W-1:0]  kept_q;
	logic [dtsc_pkg::IDX_W-1:0]  kept_base;
	logic                        in_acc;
	logic                        emit_busy;
	dtsc_pkg::coords_t           coords_cur;
	dtsc_pkg::coords_t           out_coords;
	dtsc_pkg::mem_wr_t           wr;
	dtsc_pkg::emit_job_t         job;

	always_comb begin
		if (row_len_q == '0) begin
			len_eff = dtsc_pkg::LEN_W'(1);
		end else if (dtsc_pkg::LEN_W'(row_len_q) > dtsc_pkg::LEN_W'(dtsc_pkg::MAX_ROW_LEN)) begin
			len_eff = dtsc_pkg::LEN_W'(dtsc_pkg::MAX_ROW_LEN);
		end else begin
			len_eff = dtsc_pkg::LEN_W'(row_len_q);
		end
	end

	// An element that could close a row is held off while the emitter is
	// still reading the other bank. Without a start flag the row closes when
	// the next position reaches the length; with one it closes at length one.
	assign may_end  = ((dtsc_pkg::LEN_W'(pos_q) + dtsc_pkg::LEN_W'(1)) >= len_eff) ||
	                  (len_eff == dtsc_pkg::LEN_W'(1));
	assign in_ready = !(emit_busy && may_end);
	assign in_acc   = in_valid && in_ready;

	// Plus and minus zero both count as zero, so the sign bit is ignored.
	assign elem_nz    = elem_dbl_q ? (|elem_bits[62:0]) : (|elem_bits[30:0]);
	assign pos_base   = tensor_start ? '0 : pos_q;
	assign kept_base  = tensor_start ? '0 : kept_q;
	assign row_nz_new = (tensor_start ? 1'b0 : row_nz_q) | elem_nz;
	assign pos_inc    = dtsc_pkg::LEN_W'(pos_base) + dtsc_pkg::LEN_W'(1);
	assign row_end    = pos_inc >= len_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			row_nz_q  <= 1'b0;
			wr_bank_q <= 1'b0;
			kept_q    <= '0;
		end else if (in_acc) begin
			if (row_end) begin
				pos_q    <= '0;
				row_nz_q <= 1'b0;
				if (row_nz_new) begin
					// The filled bank goes to the emitter; assembly moves on.
					wr_bank_q <= !wr_bank_q;
					kept_q    <= kept_base + dtsc_pkg::IDX_W'(1);
				end else begin
					kept_q <= kept_base;
				end
			end else begin
				pos_q    <= pos_inc[dtsc_pkg::POS_W-1:0];
				row_nz_q <= row_nz_new;
				kept_q   <= kept_base;
			end
		end
	end

	always_comb begin
		wr.en       = in_acc;
		wr.addr     = {wr_bank_q, pos_base};
		wr.data     = elem_bits;
		job.valid   = in_acc && row_end && row_nz_new;
		job.bank    = wr_bank_q;
		job.len     = len_eff;
		job.coords  = coords_cur;
		job.row_idx = kept_base;
		job.dbl     = elem_dbl_q;
	end

	// Row coordinates. A start flag clears them before the row is numbered;
	// the counter steps once per completed row, kept or not.
	dtsc_coord_cnt u_coord (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (in_acc && tensor_start),
		.advance     (in_acc && row_end),
		.sparse_dims (sparse_dims_q),
		.dim_size    (dim_size_q),
		.coords      (coords_cur)
	);

	// Row buffer and emitter. Results leave through a registered output stage,
	// so the next row can assemble while a result waits on out_ready.
	dtsc_row_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr           (wr),
		.job          (job),
		.busy         (emit_busy),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_bits     (out_bits),
		.out_coords   (out_coords),
		.elem_pos     (elem_pos),
		.nz_row_index (nz_row_index),
		.row_last     (row_last)
	);

	assign coord_0 = out_coords[0];
	assign coord_1 = out_coords[1];
	assign coord_2 = out_coords[2];
	assign coord_3 = out_coords[3];

endmodule

`default_nettype wire

// ----- hw/rtl/dtsc_checker.sv -----
// ----------------------------------------------------------------------------
// dtsc_checker
// Port-level checks on the result stream of the dense to sparse COO block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dense_to_sparse_coo_rows_top_defines.svh"

module dtsc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [dtsc_pkg::ELEM_W-1:0]       out_bits,
	input logic [dtsc_pkg::ELEM_POS_W-1:0]   elem_pos,
	input logic [dtsc_pkg::IDX_W-1:0]        nz_row_index,
	input logic                              row_last
);

	// A stalled result holds its element.
	`DTSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bits), "stalled result changed")

	// Inside a row the elements follow back to back with rising positions.
	`DTSC_ASSERT_NEXT(a_row_stream, out_valid && out_ready && !row_last, out_valid && (elem_pos == $past(elem_pos) + 6'd1) && $stable(nz_row_index), "row stream broken")

	// After the last element of a row, the next result opens a new row.
	`DTSC_ASSERT_NEXT(a_row_start, out_valid && out_ready && row_last, !out_valid || (elem_pos == '0), "new row does not start at position zero")

	// An element in the last buffer slot always ends its row.
	`DTSC_ASSERT_SAME(a_pos_range, out_valid && !row_last, elem_pos != '1, "last slot not flagged last")

endmodule

bind dense_to_sparse_coo_rows_top dtsc_checker u_dtsc_checker (.*);

`default_nettype wire
